/* rtl/core/krt_pkg.sv */
// Package: shared types and codes for the keyed record table.
package krt_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_UPDATE = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_SPARE   = 2'd3
  } status_t;

  // One stored record
  typedef struct packed {
    logic [31:0] record_key;
    logic [31:0] price_word;
    logic [31:0] stock_count;
  } rec_t;

  // One accepted request
  typedef struct packed {
    op_t         op;
    logic [31:0] record_key;
    logic [31:0] price_word;
    logic [31:0] stock_count;
  } req_t;

  // One result item
  typedef struct packed {
    status_t     status;
    logic [31:0] found_price;
    logic [31:0] found_stock;
    logic [7:0]  entries_used;
  } rsp_t;

endpackage

/* rtl/core/keyed_record_table.sv */
// Top level: keyed record table with stream request and result channels.
// Keyed record table. Records (key, price word, quantity) are held packed
// in insertion order in a single-port-read record memory. Insert answers
// without a scan; lookup, update and remove scan the memory one entry per
// cycle (a lookup stops early on a hit), and remove then moves every later
// entry down one place at one entry per cycle. One item is in work at a
// time; the next item is taken the cycle after its result is delivered.
module keyed_record_table
  import krt_pkg::*;
#(
  parameter int TABLE_DEPTH = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,  // op[1:0], record_key[33:2], price_word[65:34],
                                  // stock_count[97:66], zero[103:98]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [79:0]  out_tdata  // status[1:0], found_price[33:2],
                                  // found_stock[65:34], entries_used[73:66], zero[79:74]
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  req_t          req;
  rsp_t          rsp;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  rec_t          mem_wdata;
  rec_t          mem_rdata;

  assign req.op          = op_t'(in_tdata[1:0]);
  assign req.record_key  = in_tdata[33:2];
  assign req.price_word  = in_tdata[65:34];
  assign req.stock_count = in_tdata[97:66];

  assign out_tdata = {6'd0, rsp.entries_used, rsp.found_stock, rsp.found_price, rsp.status};

  krt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .rsp_valid (out_tvalid),
    .rsp_ready (out_tready),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  krt_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

/* rtl/core/krt_mem.sv */
// Record memory: one write port, one registered read port.
module krt_mem
  import krt_pkg::*;
#(
  parameter int TABLE_DEPTH = 128,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  rec_t          wdata,
  input  logic [AW-1:0] raddr,
  output rec_t          rdata
);

  rec_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/krt_ctrl.sv */
// Sequencer: scans the record memory one entry per cycle and applies the operation.
module krt_ctrl
  import krt_pkg::*;
#(
  parameter int TABLE_DEPTH = 128,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  output logic          req_ready,
  input  req_t          req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rsp_t          rsp,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output rec_t          mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  rec_t          mem_rdata
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_RESP} state_t;

  state_t        state_r;
  req_t          req_r;
  logic [CW-1:0] fill_r;
  logic [CW-1:0] idx_r;   // entry whose data arrives this cycle
  logic          any_r;
  rsp_t          rsp_r;

  logic          hit;
  logic [CW-1:0] idx_inc;
  status_t       idle_status;
  logic [CW-1:0] idle_fill;

  assign hit     = (mem_rdata.record_key == req_r.record_key);
  assign idx_inc = idx_r + CW'(1);

  // Status and count for an item taken in idle
  always_comb begin
    idle_status = ST_OK;
    idle_fill   = fill_r;
    if (req.op == OP_INSERT) begin
      if (fill_r < CW'(TABLE_DEPTH)) begin
        idle_fill = fill_r + CW'(1);
      end else begin
        idle_status = ST_FULL;
      end
    end else if (fill_r == '0) begin
      idle_status = ST_MISSING;
    end
  end

  // Read address: next entry during scan/shift
  always_comb begin
    mem_raddr = AW'(idx_inc);
    if (state_r == S_IDLE) begin
      mem_raddr = '0;
    end
  end

  // Write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(idx_r);
    mem_wdata = mem_rdata;
    unique case (state_r)
      S_IDLE: begin
        if (req_valid && req.op == OP_INSERT && fill_r < CW'(TABLE_DEPTH)) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(fill_r);
          mem_wdata = '{req.record_key, req.price_word, req.stock_count};
        end
      end
      S_SCAN: begin
        if (req_r.op == OP_UPDATE && hit) begin
          mem_we    = 1'b1;
          mem_wdata = '{mem_rdata.record_key, req_r.price_word, req_r.stock_count};
        end
      end
      S_SHIFT: begin
        // entry idx_r moves down to idx_r-1
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_r - CW'(1));
      end
      default: ;
    endcase
  end

  assign req_ready = (state_r == S_IDLE);
  assign rsp_valid = (state_r == S_RESP);
  assign rsp       = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            req_r  <= req;
            idx_r  <= '0;
            any_r  <= 1'b0;
            fill_r <= idle_fill;
            rsp_r  <= '{idle_status, 32'd0, 32'd0, 8'(idle_fill)};
            if (req.op == OP_INSERT || fill_r == '0) begin
              state_r <= S_RESP;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          idx_r <= idx_inc;
          if (hit) begin
            any_r <= 1'b1;
          end
          priority if (hit && req_r.op == OP_LOOKUP) begin
            rsp_r   <= '{rsp_r.status, mem_rdata.price_word, mem_rdata.stock_count,
                         rsp_r.entries_used};
            state_r <= S_RESP;
          end else if (hit && req_r.op == OP_REMOVE) begin
            fill_r <= fill_r - CW'(1);
            rsp_r.entries_used <= 8'(fill_r - CW'(1));
            state_r <= (idx_inc == fill_r) ? S_RESP : S_SHIFT;
          end else if (idx_inc == fill_r) begin
            if (!(hit || any_r)) begin
              rsp_r.status <= ST_MISSING;
            end
            state_r <= S_RESP;
          end
        end
        S_SHIFT: begin
          // fill_r already decremented: last source index is fill_r
          idx_r <= idx_inc;
          if (idx_r == fill_r) begin
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (rsp_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/krt_checker.sv */
// Port checker for the keyed record table, bound to the top level.
module krt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);

  // A held result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // One item at a time: no request taken while a result is shown
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while result pending");

  // An accepted item is never answered in the same cycle
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid || !$past(out_tvalid))
    else $error("result without work");

  // Status code three is never produced
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("bad status");

endmodule

bind keyed_record_table krt_checker u_krt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* tb/testbench.sv */
// Testbench for the keyed record table: random and directed table operations against a predictor.
module testbench;
  import krt_pkg::*;

  localparam int DEPTH = 128;
  localparam int CYCLE_LIMIT = 2000000;

  // Predicted results, oldest first, with a running count of mismatches
  class table_scoreboard;
    logic [31:0] keys[DEPTH];
    logic [31:0] prices[DEPTH];
    logic [31:0] stocks[DEPTH];
    int          fill;
    rsp_t        pending[$];
    int          errors;

    function void note_request(req_t r);
      rsp_t res;
      int   hit;
      bit   any;
      res = '0;
      res.status = ST_OK;
      hit = -1;
      for (int k = 0; k < fill; k++) begin
        if (hit < 0 && keys[k] == r.record_key) hit = k;
      end
      case (r.op)
        OP_INSERT: begin
          if (fill >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            keys[fill] = r.record_key;
            prices[fill] = r.price_word;
            stocks[fill] = r.stock_count;
            fill++;
          end
        end
        OP_LOOKUP: begin
          if (hit >= 0) begin
            res.found_price = prices[hit];
            res.found_stock = stocks[hit];
          end else begin
            res.status = ST_MISSING;
          end
        end
        OP_UPDATE: begin
          any = 0;
          for (int k = 0; k < fill; k++) begin
            if (keys[k] == r.record_key) begin
              prices[k] = r.price_word;
              stocks[k] = r.stock_count;
              any = 1;
            end
          end
          if (!any) res.status = ST_MISSING;
        end
        default: begin
          if (hit >= 0) begin
            for (int k = hit; k + 1 < fill; k++) begin
              keys[k] = keys[k+1];
              prices[k] = prices[k+1];
              stocks[k] = stocks[k+1];
            end
            fill--;
          end else begin
            res.status = ST_MISSING;
          end
        end
      endcase
      res.entries_used = fill[7:0];
      pending.push_back(res);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: status %0d/%0d price %h/%h stock %h/%h used %0d/%0d",
                   want.status, got.status, want.found_price, got.found_price,
                   want.found_stock, got.found_stock, want.entries_used, got.entries_used);
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [79:0]  out_tdata;

  table_scoreboard sb;
  int           cycles;
  bit           quiet;      // no idling in the last part
  logic [31:0]  key_pool[8];

  keyed_record_table #(.TABLE_DEPTH(DEPTH)) u_top (.*);

  always #2 clk = ~clk;

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Note accepted requests, check accepted results
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_request(req_t'({in_tdata[1:0], in_tdata[33:2], in_tdata[65:34],
                              in_tdata[97:66]}));
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(rsp_t'({out_tdata[1:0], out_tdata[33:2], out_tdata[65:34],
                              out_tdata[73:66]}));
  end

  // Result side stalls in bursts
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 17);
        out_tready <= 0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1;
    end
  end

  // Present one request and wait for its acceptance
  task automatic send_op(op_t op, logic [31:0] key, logic [31:0] price, logic [31:0] stock);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 17);
      in_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {6'b0, stock, price, key, op};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  initial begin
    op_t op;
    int  r;
    sb = new();
    cycles = 0;
    quiet = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'hffff_ffff;
    key_pool[3] = 32'h0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: misses on empty table, extremes, duplicates, remove
    send_op(OP_LOOKUP, 32'h0, 32'h0, 32'h0);
    send_op(OP_REMOVE, 32'h0, 32'h0, 32'h0);
    send_op(OP_UPDATE, 32'h0, 32'h1, 32'h1);
    send_op(OP_INSERT, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff);
    send_op(OP_INSERT, 32'h7fff_ffff, 32'h0, 32'h8000_0000);
    send_op(OP_INSERT, 32'h8000_0000, 32'h1234_5678, 32'hffff_ffff);
    send_op(OP_LOOKUP, 32'h8000_0000, 32'h0, 32'h0);
    send_op(OP_UPDATE, 32'h8000_0000, 32'haaaa_5555, 32'h5555_aaaa);
    send_op(OP_LOOKUP, 32'h8000_0000, 32'h0, 32'h0);
    send_op(OP_REMOVE, 32'h8000_0000, 32'h0, 32'h0);
    send_op(OP_LOOKUP, 32'h8000_0000, 32'h0, 32'h0);
    send_op(OP_LOOKUP, 32'h7fff_ffff, 32'h0, 32'h0);
    send_op(OP_REMOVE, 32'h7fff_ffff, 32'h0, 32'h0);
    send_op(OP_LOOKUP, 32'h1, 32'h0, 32'h0);

    // Fill to full, overflow, drain partly
    for (int i = 0; i < DEPTH + 3; i++)
      send_op(OP_INSERT, ($urandom_range(0, 1)) ? pick_key() : $urandom, $urandom, $urandom);
    for (int i = 0; i < 40; i++)
      send_op(($urandom_range(0, 1)) ? OP_REMOVE : OP_LOOKUP, pick_key(), $urandom, $urandom);

    // Random mix; the final stretch has no idling
    for (int i = 0; i < 1070; i++) begin
      if (i == 920) quiet = 1;
      r = $urandom_range(0, 9);
      op = (r < 4) ? OP_INSERT : (r < 6) ? OP_LOOKUP : (r < 8) ? OP_UPDATE : OP_REMOVE;
      if (sb.fill > 100 && op == OP_INSERT && $urandom_range(0, 1)) op = OP_REMOVE;
      send_op(op, pick_key(), $urandom, $urandom);
    end
    in_tvalid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

/* keyed_record_table.f */
rtl/core/krt_pkg.sv
rtl/core/krt_mem.sv
rtl/core/krt_ctrl.sv
rtl/core/keyed_record_table.sv
rtl/core/krt_checker.sv
tb/testbench.sv
